>>> sv/slst_pkg.sv
// shared types and constants for the sorted list engine
// used by slst_cell, slst_ctrl and sorted_list_engine_core; no dependencies
package slst_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 6;
    localparam int POS_W = 5;
    localparam int REQ_W = 2;
    localparam int STAT_W = 2;
    localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_GET    = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_RANGE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } t_state;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                    cmp_en;
        logic                    ins_en;
        logic                    rem_en;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        count;
        logic [POS_W-1:0]        pos;
    } t_cell_ctl;

endpackage

>>> sv/slst_cell.sv
// one list slot: holds an entry, compares it with the request value and
// shifts with its neighbors on insert or remove; depends on slst_pkg
module slst_cell #(
    parameter int IDX = 0
) (
    input  logic                            i_clk,
    input  slst_pkg::t_cell_ctl             i_ctl,
    input  logic signed [slst_pkg::VAL_W-1:0] i_left_val,
    input  logic                            i_left_inr,
    input  logic                            i_left_lt,
    input  logic signed [slst_pkg::VAL_W-1:0] i_right_val,
    output logic signed [slst_pkg::VAL_W-1:0] o_val,
    output logic                            o_inr,
    output logic                            o_lt,
    output logic                            o_eq
);

    logic signed [slst_pkg::VAL_W-1:0] r_val;
    logic                              r_inr;
    logic                              r_lt;
    logic                              r_eq;
    logic                              w_inr;

    assign w_inr = (IDX < int'(i_ctl.count));

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_inr <= w_inr;
            r_lt  <= w_inr & (r_val < i_ctl.value);
            r_eq  <= w_inr & (r_val == i_ctl.value);
        end
        if (i_ctl.ins_en) begin
            // left neighbor at or above the insert point moves up into this slot
            if (i_left_inr && !i_left_lt) begin
                r_val <= i_left_val;
            end else if (!r_lt) begin
                r_val <= i_ctl.value;
            end
        end else if (i_ctl.rem_en) begin
            if (!r_lt) begin
                r_val <= i_right_val;
            end
        end
    end

    assign o_val = r_val;
    assign o_inr = r_inr;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

>>> sv/slst_ctrl.sv
// request sequencer: input and config transfers, entry count, capacity,
// result register; depends on slst_pkg
module slst_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [slst_pkg::REQ_W-1:0]       i_req,
    input  logic signed [slst_pkg::VAL_W-1:0] i_value,
    input  logic [slst_pkg::POS_W-1:0]       i_pos,
    input  logic                             i_cfg_valid,
    input  logic [slst_pkg::CNT_W-1:0]       i_cfg_data,
    input  logic                             i_found,
    input  logic [slst_pkg::POS_W-1:0]       i_fidx,
    input  logic signed [slst_pkg::VAL_W-1:0] i_rdata,
    output slst_pkg::t_cell_ctl              o_ctl,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [slst_pkg::STAT_W-1:0]      o_status,
    output logic [slst_pkg::POS_W-1:0]       o_fidx,
    output logic signed [slst_pkg::VAL_W-1:0] o_rval,
    output logic [slst_pkg::CNT_W-1:0]       o_count
);

    slst_pkg::t_state                  r_state, n_state;
    slst_pkg::t_req                    r_req;
    logic signed [slst_pkg::VAL_W-1:0] r_value;
    logic [slst_pkg::POS_W-1:0]        r_pos;
    logic [slst_pkg::CNT_W-1:0]        r_count, n_count;
    logic [slst_pkg::CNT_W-1:0]        r_cap;
    logic                              r_out_valid;
    slst_pkg::t_status                 r_status, n_status;
    logic [slst_pkg::POS_W-1:0]        r_fidx, n_fidx;
    logic signed [slst_pkg::VAL_W-1:0] r_rval, n_rval;
    logic                              w_exec_go;
    logic                              w_accept;
    logic                              w_full;
    logic                              w_range;

    assign w_exec_go = (r_state == slst_pkg::ST_EXEC) && (!r_out_valid || i_out_ready);
    // no input transfer while reset is held
    assign o_in_ready = i_rst_n && ((r_state == slst_pkg::ST_IDLE) || w_exec_go);
    assign w_accept = i_in_valid && o_in_ready;

    assign w_full = (r_count >= r_cap) || (int'(r_count) >= DEPTH);
    assign w_range = ({1'b0, r_pos} >= r_count) || (int'(r_pos) >= DEPTH);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = slst_pkg::STAT_OK;
        n_fidx   = '0;
        n_rval   = '0;
        o_ctl.cmp_en = (r_state == slst_pkg::ST_CMP);
        o_ctl.ins_en = 1'b0;
        o_ctl.rem_en = 1'b0;
        o_ctl.value  = r_value;
        o_ctl.count  = r_count;
        o_ctl.pos    = r_pos;
        case (r_req)
            slst_pkg::REQ_INSERT: begin
                if (w_full) begin
                    n_status = slst_pkg::STAT_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    o_ctl.ins_en = w_exec_go;
                end
            end
            slst_pkg::REQ_REMOVE: begin
                if (!i_found) begin
                    n_status = slst_pkg::STAT_NOT_FOUND;
                end else begin
                    n_count = r_count - 1'b1;
                    o_ctl.rem_en = w_exec_go;
                end
            end
            slst_pkg::REQ_SEARCH: begin
                if (!i_found) begin
                    n_status = slst_pkg::STAT_NOT_FOUND;
                end else begin
                    n_fidx = i_fidx;
                end
            end
            slst_pkg::REQ_GET: begin
                if (w_range) begin
                    n_status = slst_pkg::STAT_RANGE;
                end else begin
                    n_rval = i_rdata;
                end
            end
            default: begin
                n_status = slst_pkg::STAT_OK;
            end
        endcase
        case (r_state)
            slst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = slst_pkg::ST_CMP;
                end
            end
            slst_pkg::ST_CMP: begin
                n_state = slst_pkg::ST_EXEC;
            end
            slst_pkg::ST_EXEC: begin
                if (w_exec_go) begin
                    n_state = w_accept ? slst_pkg::ST_CMP : slst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slst_pkg::ST_IDLE;
            r_count     <= '0;
            r_cap       <= slst_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (w_exec_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= slst_pkg::t_req'(i_req);
            r_value <= i_value;
            r_pos   <= i_pos;
        end
        if (w_exec_go) begin
            r_status <= n_status;
            r_fidx   <= n_fidx;
            r_rval   <= n_rval;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_fidx      = r_fidx;
    assign o_rval      = r_rval;
    assign o_count     = r_count;

endmodule

>>> sv/sorted_list_engine_core.sv
// sorted list engine: a row of compare-and-shift cells under one sequencer
// a request is compared, then its result registered in the update state
// the next request can be taken in the update cycle, not in the compare cycle
// a stalled result holds the update cycle until the output transfer frees it
// reset (synchronous, active low): count 0, capacity 32, no result pending;
// stored entries are not cleared, slots at or above the count are never read
module sorted_list_engine_core #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // found_index[4:0], read_value[36:5],
                                        // entry_count[42:37], zero pad
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data      // capacity
);

    // the count never exceeds 63, so no more slots can ever hold an entry
    localparam int NCELL = (DEPTH < 63) ? DEPTH : 63;
    localparam int NREAD = (NCELL < 32) ? NCELL : 32;

    slst_pkg::t_cell_ctl               w_ctl;
    logic signed [slst_pkg::VAL_W-1:0] w_val [NCELL];
    logic                              w_inr [NCELL];
    logic                              w_lt  [NCELL];
    logic                              w_eq  [NCELL];
    logic                              w_found;
    logic [slst_pkg::POS_W-1:0]        w_fidx;
    logic signed [slst_pkg::VAL_W-1:0] w_rdata;
    logic [slst_pkg::STAT_W-1:0]       w_status;
    logic [slst_pkg::POS_W-1:0]        w_out_fidx;
    logic signed [slst_pkg::VAL_W-1:0] w_out_rval;
    logic [slst_pkg::CNT_W-1:0]        w_out_count;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            logic signed [slst_pkg::VAL_W-1:0] w_left_val;
            logic                              w_left_inr;
            logic                              w_left_lt;
            logic signed [slst_pkg::VAL_W-1:0] w_right_val;
            if (g == 0) begin : g_first
                assign w_left_val = '0;
                assign w_left_inr = 1'b0;
                assign w_left_lt  = 1'b0;
            end else begin : g_mid
                assign w_left_val = w_val[g-1];
                assign w_left_inr = w_inr[g-1];
                assign w_left_lt  = w_lt[g-1];
            end
            if (g == NCELL - 1) begin : g_last
                assign w_right_val = w_val[g];
            end else begin : g_inner
                assign w_right_val = w_val[g+1];
            end
            slst_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_left_val  (w_left_val),
                .i_left_inr  (w_left_inr),
                .i_left_lt   (w_left_lt),
                .i_right_val (w_right_val),
                .o_val       (w_val[g]),
                .o_inr       (w_inr[g]),
                .o_lt        (w_lt[g]),
                .o_eq        (w_eq[g])
            );
        end
    endgenerate

    // first match sits where the less-than flags stop
    always_comb begin
        w_found = w_eq[0];
        w_fidx  = '0;
        for (int i = 1; i < NCELL; i++) begin
            w_found = w_found | w_eq[i];
            if (w_eq[i] && w_lt[i-1]) begin
                w_fidx = w_fidx | slst_pkg::POS_W'(i);
            end
        end
    end

    always_comb begin
        w_rdata = '0;
        for (int i = 0; i < NREAD; i++) begin
            if (int'(w_ctl.pos) == i) begin
                w_rdata = w_rdata | w_val[i];
            end
        end
    end

    slst_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req       (s_axis_tuser),
        .i_value     (s_axis_tdata[31:0]),
        .i_pos       (s_axis_tdata[36:32]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_found     (w_found),
        .i_fidx      (w_fidx),
        .i_rdata     (w_rdata),
        .o_ctl       (w_ctl),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_fidx      (w_out_fidx),
        .o_rval      (w_out_rval),
        .o_count     (w_out_count)
    );

    // config transfers are taken whenever reset is released
    assign o_cfg_ready  = i_rst_n;
    assign m_axis_tuser = w_status;
    assign m_axis_tdata = {5'b0, w_out_count, w_out_rval, w_out_fidx};

endmodule

>>> sv/slst_chk.sv
// port-level checks for sorted_list_engine_core, attached with bind
// depends on slst_pkg for the status codes
module slst_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [5:0]  i_cfg_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one request at a time: the compare cycle never takes a transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken during compare cycle");

    a_err_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == slst_pkg::STAT_RANGE
            || m_axis_tuser == slst_pkg::STAT_NOT_FOUND
            || m_axis_tuser == slst_pkg::STAT_FULL)
        |-> m_axis_tdata[36:0] == 37'd0)
        else $error("error result carries data");

endmodule

bind sorted_list_engine_core slst_chk u_slst_chk (.*);

>>> verif/tb_sorted_list_engine_core.sv
// self-checking testbench for sorted_list_engine_core: directed table, then random phases
// depends on slst_pkg and sorted_list_engine_core; predicts most results from its own list copy
`timescale 1ns / 100ps

module tb_sorted_list_engine_core;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 9;
    localparam int N_DIRECTED  = 22;
    localparam int VAL_W       = slst_pkg::VAL_W;
    localparam int POS_W       = slst_pkg::POS_W;
    localparam int CNT_W       = slst_pkg::CNT_W;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    typedef struct {
        slst_pkg::t_status       status;
        logic [POS_W-1:0]        fidx;
        logic signed [VAL_W-1:0] rval;
        logic [CNT_W-1:0]        cnt;
    } t_list_result;

    typedef struct {
        slst_pkg::t_req          req;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
        bit                      typed;
        slst_pkg::t_status       status;
        logic [POS_W-1:0]        fidx;
        logic signed [VAL_W-1:0] rval;
        logic [CNT_W-1:0]        cnt;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data = 6'd32;

    // predictor state
    logic signed [VAL_W-1:0] list_mem [DEPTH];
    int                      list_len = 0;
    int                      cap_reg = 32;

    t_list_result pending_results [$];
    t_stim_row    directed_rows [N_DIRECTED];

    t_idle idle_mode = IDLE_NONE;
    int cycle_cnt = 0;
    int mismatch_cnt = 0;
    int results_seen = 0;
    int items_sent = 0;
    int full_seen = 0;
    int miss_seen = 0;
    int range_seen = 0;
    int cfg_writes = 0;

    logic signed [VAL_W-1:0] val_pool [8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
                                              32'sd1, 32'sd5, 32'sd1000, -32'sd77};
    int phase_cap [N_PHASES]  = '{32, 32, 1, 5, 17, 2, 31, 32, 8};
    t_idle phase_mode [N_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE,
                                     IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};
    int phase_len [N_PHASES]  = '{60, 70, 60, 80, 80, 60, 80, 80, 70};
    int phase_ins [N_PHASES]  = '{80, 90, 40, 30, 50, 50, 70, 60, 45};

    sorted_list_engine_core #(.DEPTH(DEPTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // value[31:0], position[36:32], zero pad
        .s_axis_tuser  (s_axis_tuser),   // req_type[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // found_index[4:0], read_value[36:5],
                                         // entry_count[42:37], zero pad
        .m_axis_tuser  (m_axis_tuser),   // status[1:0]
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_list_result apply_request(slst_pkg::t_req req,
                                                   logic signed [VAL_W-1:0] v,
                                                   logic [POS_W-1:0] pos);
        t_list_result r;
        int eff_cap;
        int i;
        int p;
        r.status = slst_pkg::STAT_OK;
        r.fidx = '0;
        r.rval = '0;
        eff_cap = (cap_reg < DEPTH) ? cap_reg : DEPTH;
        case (req)
            slst_pkg::REQ_INSERT: begin
                if (list_len < eff_cap) begin
                    i = 0;
                    while (i < list_len && list_mem[i] < v) i++;
                    for (p = list_len; p > i; p--) list_mem[p] = list_mem[p-1];
                    list_mem[i] = v;
                    list_len++;
                end else begin
                    r.status = slst_pkg::STAT_FULL;
                end
            end
            slst_pkg::REQ_REMOVE, slst_pkg::REQ_SEARCH: begin
                p = 0;
                while (p < list_len && list_mem[p] != v) p++;
                if (p >= list_len) begin
                    r.status = slst_pkg::STAT_NOT_FOUND;
                end else if (req == slst_pkg::REQ_SEARCH) begin
                    r.fidx = p[POS_W-1:0];
                end else begin
                    for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            default: begin
                if (int'(pos) >= list_len) r.status = slst_pkg::STAT_RANGE;
                else r.rval = list_mem[pos];
            end
        endcase
        r.cnt = list_len[CNT_W-1:0];
        return r;
    endfunction

    // one request: optional sender gap, then hold tvalid until the transfer
    task automatic send_item(input t_stim_row row);
        t_list_result r;
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < 77) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 15)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, row.pos, row.value};
        s_axis_tuser <= row.req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = apply_request(row.req, row.value, row.pos);
        if (row.typed) begin
            r.status = row.status;
            r.fidx = row.fidx;
            r.rval = row.rval;
            r.cnt = row.cnt;
        end
        pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap[5:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_reg = cap;
        cfg_writes++;
    endtask

    function automatic t_stim_row random_row(input int ins_w);
        t_stim_row row;
        int pick;
        row.typed = 1'b0;
        row.status = slst_pkg::STAT_OK;
        row.fidx = '0;
        row.rval = '0;
        row.cnt = '0;
        row.pos = POS_W'($urandom_range(31));
        if ($urandom_range(99) < ins_w) begin
            row.req = slst_pkg::REQ_INSERT;
        end else begin
            pick = $urandom_range(2);
            row.req = (pick == 0) ? slst_pkg::REQ_REMOVE :
                      (pick == 1) ? slst_pkg::REQ_SEARCH : slst_pkg::REQ_GET;
        end
        pick = $urandom_range(99);
        if (row.req != slst_pkg::REQ_INSERT && list_len > 0 && pick < 60)
            row.value = list_mem[$urandom_range(list_len - 1)];
        else if (pick < 80)
            row.value = val_pool[$urandom_range(7)];
        else
            row.value = $urandom;
        // mostly valid positions so gets read real entries
        if (row.req == slst_pkg::REQ_GET && list_len > 0 && $urandom_range(3) != 0)
            row.pos = POS_W'($urandom_range(list_len - 1));
        return row;
    endfunction

    task automatic check_result(input t_list_result exp_r, input t_list_result got_r);
        if (got_r.status != exp_r.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_r.status, got_r.status);
            mismatch_cnt++;
        end
        if (got_r.fidx != exp_r.fidx) begin
            $display("%0t: found_index expected %0d got %0d", $time, exp_r.fidx, got_r.fidx);
            mismatch_cnt++;
        end
        if (got_r.rval != exp_r.rval) begin
            $display("%0t: read_value expected %0d got %0d", $time, exp_r.rval, got_r.rval);
            mismatch_cnt++;
        end
        if (got_r.cnt != exp_r.cnt) begin
            $display("%0t: entry_count expected %0d got %0d", $time, exp_r.cnt, got_r.cnt);
            mismatch_cnt++;
        end
    endtask

    // result side: random stall and in-order compare
    always @(posedge i_clk) begin
        t_list_result got_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r.status = slst_pkg::t_status'(m_axis_tuser);
            got_r.fidx = m_axis_tdata[4:0];
            got_r.rval = m_axis_tdata[36:5];
            got_r.cnt = m_axis_tdata[42:37];
            results_seen++;
            if (got_r.status == slst_pkg::STAT_FULL) full_seen++;
            if (got_r.status == slst_pkg::STAT_NOT_FOUND) miss_seen++;
            if (got_r.status == slst_pkg::STAT_RANGE) range_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d count %0d", $time,
                         got_r.status, got_r.cnt);
                mismatch_cnt++;
            end else begin
                check_result(pending_results.pop_front(), got_r);
            end
        end
        m_axis_tready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 77) ||
                           (idle_mode == IDLE_BOTH && $urandom_range(99) < 15));
    end

    initial begin
        int ph;
        int n;
        directed_rows = '{
            '{slst_pkg::REQ_GET,    32'sd0,         5'd0,  1'b1,
              slst_pkg::STAT_RANGE,     5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_REMOVE, 32'sd0,         5'd0,  1'b1,
              slst_pkg::STAT_NOT_FOUND, 5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_SEARCH, 32'sd0,         5'd0,  1'b1,
              slst_pkg::STAT_NOT_FOUND, 5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_INSERT, 32'sh7fff_ffff, 5'd0,  1'b1,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd1},
            '{slst_pkg::REQ_INSERT, 32'sh8000_0000, 5'd31, 1'b1,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd2},
            '{slst_pkg::REQ_GET,    32'sd0,         5'd0,  1'b1,
              slst_pkg::STAT_OK,        5'd0, 32'sh8000_0000, 6'd2},
            '{slst_pkg::REQ_GET,    32'sd0,         5'd1,  1'b1,
              slst_pkg::STAT_OK,        5'd0, 32'sh7fff_ffff, 6'd2},
            '{slst_pkg::REQ_INSERT, 32'sd0,         5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_INSERT, 32'sd0,         5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_INSERT, -32'sd1,        5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_INSERT, 32'sd1,         5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_SEARCH, 32'sd0,         5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_SEARCH, 32'sh7fff_ffff, 5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_SEARCH, 32'sd12345,     5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_GET,    32'sd0,         5'd31, 1'b1,
              slst_pkg::STAT_RANGE,     5'd0, 32'sd0,         6'd6},
            '{slst_pkg::REQ_GET,    32'sd0,         5'd5,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_GET,    32'sd0,         5'd6,  1'b1,
              slst_pkg::STAT_RANGE,     5'd0, 32'sd0,         6'd6},
            '{slst_pkg::REQ_REMOVE, 32'sd0,         5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_REMOVE, 32'sh8000_0000, 5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_REMOVE, 32'sd99,        5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_SEARCH, 32'sd0,         5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0},
            '{slst_pkg::REQ_GET,    32'sd0,         5'd0,  1'b0,
              slst_pkg::STAT_OK,        5'd0, 32'sd0,         6'd0}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < N_DIRECTED; n++) send_item(directed_rows[n]);
        drain_results();

        // capacity changes only while idle; some phases drop it below the count
        for (ph = 0; ph < N_PHASES; ph++) begin
            write_capacity(phase_cap[ph]);
            idle_mode = phase_mode[ph];
            for (n = 0; n < phase_len[ph]; n++) send_item(random_row(phase_ins[ph]));
            drain_results();
            idle_mode = IDLE_NONE;
        end

        $display("run: %0d requests (%0d directed), %0d capacity writes, %0d results checked",
                 items_sent, N_DIRECTED, cfg_writes, results_seen);
        $display("run: %0d full, %0d not found, %0d out of range, %0d mismatches",
                 full_seen, miss_seen, range_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
